// File: rtl/core/srtcnt_pkg.sv
// Shared types and constants for the count-then-code record sorter.
`timescale 1ns / 1ps

package srtcnt_pkg;

    localparam int CODE_W        = 17;
    localparam int COUNT_W       = 20;
    localparam int DEPTH_DEFAULT = 64;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  code;
    } rec_t;

    typedef struct packed {
        logic ins;    // place the broadcast word into the chain
        logic shift;  // move every cell toward cell 0
    } cell_ctl_t;

    // True when record a sorts ahead of record b: by count, then by code.
    function automatic logic goes_before(input rec_t a, input rec_t b);
        logic res;
        if (a.count != b.count) begin
            res = (a.count < b.count);
        end else begin
            res = (a.code < b.code);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/srtcnt_cell.sv
// One cell of the sorted insertion chain: holds a record, moves it up or down.
`timescale 1ns / 1ps

module srtcnt_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  srtcnt_pkg::cell_ctl_t ctl,
    input  srtcnt_pkg::rec_t      new_rec,
    input  srtcnt_pkg::rec_t      prev_rec,
    input  logic                  prev_disp,
    input  srtcnt_pkg::rec_t      next_rec,
    output srtcnt_pkg::rec_t      rec,
    output logic                  disp
);

    srtcnt_pkg::rec_t rec_reg;
    srtcnt_pkg::rec_t rec_next;

    // This cell gives up its place when it is empty or the new word sorts ahead.
    assign disp = !rec_reg.valid || srtcnt_pkg::goes_before(new_rec, rec_reg);
    assign rec  = rec_reg;

    always_comb begin
        rec_next = rec_reg;
        if (ctl.shift) begin
            rec_next = next_rec;
        end else if (ctl.ins) begin
            if (prev_disp) begin
                rec_next = prev_rec;
            end else if (disp) begin
                rec_next = new_rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.valid <= 1'b0;
        end else begin
            rec_reg.valid <= rec_next.valid;
        end
        rec_reg.count <= rec_next.count;
        rec_reg.code  <= rec_next.code;
    end

endmodule

// File: rtl/core/record_sorter_by_count_then_key_unit.sv
// Record sorter top level: insertion chain of cells, then sorted read-out.
// Each input word is placed into the sorted chain as it is taken, so words
// are taken back to back while a batch is loading. After the word marked
// last, the first sorted word appears on the next cycle and one word leaves
// per cycle from cell 0 while m_ready is high; input is held off until the
// batch is drained. Reset empties every cell and clears the drop flag.
`timescale 1ns / 1ps

module record_sorter_by_count_then_key_unit #(
    parameter int DEPTH = srtcnt_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [srtcnt_pkg::CODE_W-1:0]  s_code,
    input  logic [srtcnt_pkg::COUNT_W-1:0] s_count,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [srtcnt_pkg::CODE_W-1:0]  m_sorted_code,
    output logic [srtcnt_pkg::COUNT_W-1:0] m_sorted_count,
    output logic                           m_final_res,
    output logic                           m_dropped
);

    srtcnt_pkg::rec_t      recs [DEPTH];
    logic                  disp [DEPTH];
    srtcnt_pkg::rec_t      new_rec;
    srtcnt_pkg::rec_t      empty_rec;
    srtcnt_pkg::cell_ctl_t ctl;

    logic emit_reg, emit_next;
    logic ovf_reg, ovf_next;
    logic s_fire, m_fire, full;

    assign s_ready = !emit_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = emit_reg && recs[0].valid;
    assign m_fire  = m_valid && m_ready;
    assign full    = recs[DEPTH-1].valid;

    assign new_rec.valid = 1'b1;
    assign new_rec.count = s_count;
    assign new_rec.code  = s_code;

    assign empty_rec = '0;

    // Drop the incoming word when the chain is full.
    assign ctl.ins   = s_fire && !full;
    assign ctl.shift = m_fire;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            srtcnt_pkg::rec_t prev_r;
            srtcnt_pkg::rec_t next_r;
            logic             prev_d;
            if (gi == 0) begin : g_head
                assign prev_r = empty_rec;
                assign prev_d = 1'b0;
            end else begin : g_mid
                assign prev_r = recs[gi-1];
                assign prev_d = disp[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign next_r = empty_rec;
            end else begin : g_body
                assign next_r = recs[gi+1];
            end
            srtcnt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .new_rec   (new_rec),
                .prev_rec  (prev_r),
                .prev_disp (prev_d),
                .next_rec  (next_r),
                .rec       (recs[gi]),
                .disp      (disp[gi])
            );
        end
    endgenerate

    assign m_sorted_code  = recs[0].code;
    assign m_sorted_count = recs[0].count;
    assign m_final_res    = !recs[1].valid;
    assign m_dropped      = ovf_reg;

    always_comb begin
        emit_next = emit_reg;
        ovf_next  = ovf_reg;
        if (s_fire && full) begin
            ovf_next = 1'b1;
        end
        if (s_fire && s_last) begin
            emit_next = 1'b1;
        end
        // End the batch once the final word leaves.
        if (m_fire && !recs[1].valid) begin
            emit_next = 1'b0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            emit_reg <= emit_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// File: bench/record_sorter_by_count_then_key_unit_tb.sv
// Testbench for the count-then-code record sorter: batches in, sorted words checked out.
`timescale 1ns / 1ps

module record_sorter_by_count_then_key_unit_tb;

    localparam int CODE_W         = srtcnt_pkg::CODE_W;
    localparam int COUNT_W        = srtcnt_pkg::COUNT_W;
    localparam int DEPTH          = srtcnt_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_WORDS   = 35;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [CODE_W-1:0]  CODE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum int {
        KEYS_WIDE,
        KEYS_TIGHT,
        KEYS_COUNT_TIES
    } key_mix_e;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
    } vote_rec_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
        logic               final_res;
        logic               dropped;
    } sorted_word_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CODE_W-1:0]   s_code;
    logic [COUNT_W-1:0]  s_count;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    logic [CODE_W-1:0]   m_sorted_code;
    logic [COUNT_W-1:0]  m_sorted_count;
    logic                m_final_res;
    logic                m_dropped;

    vote_rec_t    batch_recs[$];
    logic         batch_overflow;
    sorted_word_t expected_words[$];
    int           fail_count;
    int           idle_cycles;
    int           stall_left;
    bit           idle_on;

    record_sorter_by_count_then_key_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code         (s_code),
        .s_count        (s_count),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_code  (m_sorted_code),
        .m_sorted_count (m_sorted_count),
        .m_final_res    (m_final_res),
        .m_dropped      (m_dropped)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // True when record a sorts ahead of record b: by count, then by code.
    function automatic bit ranks_ahead(vote_rec_t a, vote_rec_t b);
        if (a.count != b.count) begin
            return a.count < b.count;
        end
        return a.code < b.code;
    endfunction

    // Insert one accepted word into the running batch; on last, queue the sorted read-out.
    task automatic sort_into_batch(vote_rec_t rec, logic last);
        int           pos;
        sorted_word_t w;
        if (batch_recs.size() >= DEPTH) begin
            batch_overflow = 1'b1;
        end else begin
            pos = batch_recs.size();
            while (pos > 0 && ranks_ahead(rec, batch_recs[pos-1])) begin
                pos--;
            end
            batch_recs.insert(pos, rec);
        end
        if (last) begin
            for (int i = 0; i < batch_recs.size(); i++) begin
                w.code      = batch_recs[i].code;
                w.count     = batch_recs[i].count;
                w.final_res = (i == batch_recs.size() - 1);
                w.dropped   = batch_overflow;
                expected_words.push_back(w);
            end
            batch_recs.delete();
            batch_overflow = 1'b0;
        end
    endtask

    // Present one word from a falling edge and hold it until it is taken.
    task automatic send_word(logic [CODE_W-1:0] code, logic [COUNT_W-1:0] count,
                             logic last);
        vote_rec_t rec;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_code  = code;
        s_count = count;
        s_last  = last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        rec.code  = code;
        rec.count = count;
        sort_into_batch(rec, last);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] pick_code(key_mix_e mix);
        if (mix == KEYS_TIGHT) begin
            return CODE_W'($urandom_range(0, 3));
        end
        return CODE_W'($urandom_range(0, (1 << CODE_W) - 1));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count(key_mix_e mix);
        if (mix == KEYS_WIDE) begin
            return COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
        end
        return COUNT_W'($urandom_range(0, 2));
    endfunction

    task automatic send_random_batch(int words, key_mix_e mix);
        for (int i = 0; i < words; i++) begin
            send_word(pick_code(mix), pick_count(mix), i == words - 1);
        end
    endtask

    // Field extremes, bit patterns, ties and a one-word batch.
    task automatic test_extremes();
        idle_on = 1'b1;
        send_word('0, '0, 1'b1);
        send_word(CODE_MAX, COUNT_MAX, 1'b0);
        send_word('0, COUNT_MAX, 1'b0);
        send_word(CODE_MAX, '0, 1'b0);
        send_word('0, '0, 1'b0);
        send_word(17'h15555, 20'hAAAAA, 1'b0);
        send_word(17'h0AAAA, 20'h55555, 1'b0);
        send_word(17'h1, 20'h1, 1'b1);
        // identical records must come out side by side
        send_word(17'd5, 20'd7, 1'b0);
        send_word(17'd5, 20'd7, 1'b0);
        send_word(17'd3, 20'd7, 1'b0);
        send_word(17'd9, 20'd6, 1'b0);
        send_word(17'd5, 20'd7, 1'b1);
        // same count, codes arriving in descending order
        send_word(17'd4, 20'd100, 1'b0);
        send_word(17'd3, 20'd100, 1'b0);
        send_word(17'd2, 20'd100, 1'b0);
        send_word(17'd1, 20'd100, 1'b1);
    endtask

    // Overfill the store, the closing word included, then check the flag clears.
    task automatic test_overflow();
        idle_on = 1'b1;
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_word(pick_code(KEYS_WIDE), pick_count(KEYS_COUNT_TIES), i == DEPTH + 1);
        end
        send_random_batch(2, KEYS_WIDE);
    endtask

    // Mostly small batches of mixed keys.
    task automatic test_random();
        int       sent;
        int       words;
        key_mix_e mix;
        idle_on = 1'b1;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            // calm stretches, and a calm tail at the end of the run
            idle_on = (sent < RANDOM_WORDS - 20) && ($urandom_range(0, 3) != 0);
            words = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                : $urandom_range(1, 8);
            mix = key_mix_e'($urandom_range(0, 2));
            send_random_batch(words, mix);
            sent += words;
        end
    endtask

    always @(negedge aclk) begin
        if (!idle_on) begin
            stall_left = 0;
            m_ready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        sorted_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: code %0d count %0d", m_sorted_code, m_sorted_count);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_sorted_code !== want.code) begin
                    $error("sorted_code: expected %0d, got %0d", want.code, m_sorted_code);
                    fail_count++;
                end
                if (m_sorted_count !== want.count) begin
                    $error("sorted_count: expected %0d, got %0d", want.count,
                           m_sorted_count);
                    fail_count++;
                end
                if (m_final_res !== want.final_res) begin
                    $error("final_res: expected %0d, got %0d", want.final_res, m_final_res);
                    fail_count++;
                end
                if (m_dropped !== want.dropped) begin
                    $error("dropped: expected %0d, got %0d", want.dropped, m_dropped);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run when neither side moves a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("record_sorter_by_count_then_key_unit_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_code         = '0;
        s_count        = '0;
        s_last         = 1'b0;
        m_ready        = 1'b0;
        batch_overflow = 1'b0;
        fail_count     = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        idle_on        = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_extremes();
        test_overflow();
        test_random();

        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("record_sorter_by_count_then_key_unit_tb OK");
        end else begin
            $display("record_sorter_by_count_then_key_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
